// File: design/ipf_pkg.sv
// shared types and constants for the integer prime factorizer
`timescale 1ns / 1ps

package ipf_pkg;

  localparam int ValueWidthDef = 32;
  localparam int QueueDepth    = 2;
  localparam int FirstDivisor  = 2;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic avail;
    logic is_empty;
  } ipf_head_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackDivStart,
    BackDivWait
  } back_state_e;

endpackage

// File: design/ipf_front.sv
// front end: accepts words, flags inputs without factors, queues them for the back end
`timescale 1ns / 1ps

module ipf_front
  import ipf_pkg::*;
#(
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   busy_o,
  input  logic                   pop_i,
  output ipf_head_t              head_o,
  output logic [VALUE_WIDTH-1:0] head_value_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [VALUE_WIDTH-1:0] val_q [QueueDepth];
  logic                   emp_q [QueueDepth];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   push;
  logic                   pop;
  logic                   is_empty;

  // zero and one have no prime factors
  assign is_empty = (value_i < VALUE_WIDTH'(FirstDivisor));

  assign busy_o = (cnt_q == CntW'(QueueDepth));
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    priority if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      val_q[wr_ptr_q] <= value_i;
      emp_q[wr_ptr_q] <= is_empty;
    end
  end

  assign head_o.avail    = (cnt_q != '0);
  assign head_o.is_empty = emp_q[rd_ptr_q];
  assign head_value_o    = val_q[rd_ptr_q];

endmodule

// File: design/ipf_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ipf_div
  import ipf_pkg::*;
#(
  parameter int VALUE_WIDTH = ValueWidthDef,
  parameter int DIV_WIDTH   = (ValueWidthDef + 1) / 2 + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [DIV_WIDTH-1:0]   divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quot_o,
  output logic [DIV_WIDTH-1:0]   rem_o
);

  localparam int CntW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quot_q;
  logic [DIV_WIDTH-1:0]   prem_q;
  logic [DIV_WIDTH-1:0]   dsr_q;
  logic [CntW-1:0]        cnt_q;
  logic                   run_q;
  logic                   done_q;
  logic [DIV_WIDTH:0]     shifted;
  logic [DIV_WIDTH:0]     diff;
  logic                   ge;

  // partial remainder shifted left by one, next dividend bit enters
  assign shifted = {prem_q, quot_q[VALUE_WIDTH-1]};
  assign ge      = (shifted >= {1'b0, dsr_q});
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(VALUE_WIDTH);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      prem_q <= '0;
      dsr_q  <= divisor_i;
    end else if (run_q) begin
      quot_q <= {quot_q[VALUE_WIDTH-2:0], ge};
      prem_q <= ge ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = prem_q;

endmodule

// File: design/ipf_back.sv
// back end: trial division sequencer and result register
`timescale 1ns / 1ps

module ipf_back
  import ipf_pkg::*;
#(
  parameter int VALUE_WIDTH = ValueWidthDef,
  parameter int DIV_WIDTH   = (ValueWidthDef + 1) / 2 + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ipf_head_t              head_i,
  input  logic [VALUE_WIDTH-1:0] head_value_i,
  output logic                   pop_o,
  output logic                   div_start_o,
  output logic [VALUE_WIDTH-1:0] div_dividend_o,
  output logic [DIV_WIDTH-1:0]   div_divisor_o,
  input  logic                   div_done_i,
  input  logic [VALUE_WIDTH-1:0] div_quot_i,
  input  logic [DIV_WIDTH-1:0]   div_rem_i,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] prime_factor_o,
  output logic                   last_o,
  output logic                   empty_res_o
);

  back_state_e            state_q, state_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [DIV_WIDTH-1:0]   dv_q, dv_d;
  logic                   fresh_q, fresh_d;
  logic                   emit;
  logic [VALUE_WIDTH-1:0] emit_factor;
  logic                   emit_last;
  logic                   emit_empty;
  logic [VALUE_WIDTH-1:0] dv_ext;
  logic                   valid_q;
  logic [VALUE_WIDTH-1:0] factor_q;
  logic                   last_q;
  logic                   empty_q;

  assign dv_ext = {{(VALUE_WIDTH - DIV_WIDTH){1'b0}}, dv_q};

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    dv_d        = dv_q;
    fresh_d     = fresh_q;
    pop_o       = 1'b0;
    div_start_o = 1'b0;
    emit        = 1'b0;
    emit_factor = '0;
    emit_last   = 1'b0;
    emit_empty  = 1'b0;
    unique case (state_q)
      BackIdle: begin
        if (head_i.avail) begin
          pop_o = 1'b1;
          if (head_i.is_empty) begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            emit_empty = 1'b1;
          end else begin
            rem_d   = head_value_i;
            dv_d    = DIV_WIDTH'(FirstDivisor);
            fresh_d = 1'b1;
            state_d = BackDivStart;
          end
        end
      end
      BackDivStart: begin
        div_start_o = 1'b1;
        state_d     = BackDivWait;
      end
      BackDivWait: begin
        if (div_done_i) begin
          priority if (fresh_q && (dv_ext > div_quot_i)) begin
            // divisor squared exceeds what is left: the rest is prime
            emit        = 1'b1;
            emit_factor = rem_q;
            emit_last   = 1'b1;
            state_d     = BackIdle;
          end else if (div_rem_i == '0) begin
            emit        = 1'b1;
            emit_factor = dv_ext;
            emit_last   = (div_quot_i == VALUE_WIDTH'(1));
            rem_d       = div_quot_i;
            fresh_d     = 1'b0;
            state_d     = (div_quot_i == VALUE_WIDTH'(1)) ? BackIdle : BackDivStart;
          end else begin
            dv_d    = dv_q + DIV_WIDTH'(1);
            fresh_d = 1'b1;
            state_d = BackDivStart;
          end
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
      valid_q <= 1'b0;
      dv_q    <= DIV_WIDTH'(FirstDivisor);
      rem_q   <= '0;
      fresh_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= emit;
      dv_q    <= dv_d;
      rem_q   <= rem_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      factor_q <= emit_factor;
      last_q   <= emit_last;
      empty_q  <= emit_empty;
    end
  end

  assign div_dividend_o = rem_q;
  assign div_divisor_o  = dv_q;
  assign valid_o        = valid_q;
  assign prime_factor_o = factor_q;
  assign last_o         = last_q;
  assign empty_res_o    = empty_q;

endmodule

// File: design/integer_prime_factorizer_unit.sv
// top level of the trial division prime factorizer
// an input of zero or one gives its single word, flagged empty and last, once the back end pops it
// each trial takes one pass of the serial divider, and each found factor one more pass too
// a 32-bit prime near 2^32 needs about 65536 trials
// busy rises once two words wait in the front queue; the receiver cannot stall results
// reset: rst_ni is asynchronous, active low, and empties the queue and idles the back end
`timescale 1ns / 1ps

module integer_prime_factorizer_unit
  import ipf_pkg::*;
#(
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   busy,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] prime_factor_o,
  output logic                   last_o,
  output logic                   empty_res_o
);

  // divisor width: enough for sqrt of the largest value plus the final increment
  localparam int DivWidth = (VALUE_WIDTH + 1) / 2 + 1;

  ipf_head_t              head;
  logic [VALUE_WIDTH-1:0] head_value;
  logic                   pop;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [DivWidth-1:0]    div_divisor;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DivWidth-1:0]    div_rem;

  // front end: takes a word whenever the queue has room
  ipf_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .value_i     (value_i),
    .busy_o      (busy),
    .pop_i       (pop),
    .head_o      (head),
    .head_value_o(head_value)
  );

  // back end: walks trial divisors upward from two
  ipf_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DIV_WIDTH  (DivWidth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_value_i  (head_value),
    .pop_o         (pop),
    .div_start_o   (div_start),
    .div_dividend_o(div_dividend),
    .div_divisor_o (div_divisor),
    .div_done_i    (div_done),
    .div_quot_i    (div_quot),
    .div_rem_i     (div_rem),
    .valid_o       (valid_o),
    .prime_factor_o(prime_factor_o),
    .last_o        (last_o),
    .empty_res_o   (empty_res_o)
  );

  // one division gives both the remainder test and the square bound (quotient)
  ipf_div #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DIV_WIDTH  (DivWidth)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

endmodule

// File: design/ipf_checker.sv
// port level checks for the prime factorizer, bound to the top level
`timescale 1ns / 1ps

module ipf_checker
  import ipf_pkg::*;
#(
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   valid_o,
  input logic [VALUE_WIDTH-1:0] prime_factor_o,
  input logic                   last_o,
  input logic                   empty_res_o
);

  // an empty word is always the only and last one, with a zero factor
  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && empty_res_o |-> last_o && (prime_factor_o == '0))
    else $error("empty word not last or factor nonzero");

  // a real factor is at least two
  a_factor_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !empty_res_o |-> (prime_factor_o >= VALUE_WIDTH'(FirstDivisor)))
    else $error("factor below two");

  // after a word that is not last the divider must run again
  a_gap_after_mid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> !valid_o)
    else $error("back to back words within one input");

endmodule

bind integer_prime_factorizer_unit ipf_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_ipf_checker (.*);
